// ===== hdl/tmcs_pkg.sv =====
`default_nettype none

package tmcs_pkg;

    // config register file
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_TIME_W = 24;
    localparam int STEP_W     = 16;

    localparam logic [REG_IDX_W-1:0] REG_MOVE_TIME    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TURN_TIME    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SWING_FIRST  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SWING_RETURN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STEP_LENGTH  = 3'd4;

    localparam logic [CFG_TIME_W-1:0] MOVE_TIME_RST    = 24'd1000;
    localparam logic [CFG_TIME_W-1:0] TURN_TIME_RST    = 24'd500;
    localparam logic [CFG_TIME_W-1:0] SWING_FIRST_RST  = 24'd2000;
    localparam logic [CFG_TIME_W-1:0] SWING_RETURN_RST = 24'd4000;
    localparam logic [STEP_W-1:0]     STEP_LENGTH_RST  = 16'd50;

    localparam int TIME_BITS_DEFAULT = 24;

    // stream payload widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;
    localparam int CMD_W     = 3;
    localparam int CAR_W     = 3;
    localparam int SWING_W   = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_STOP     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FORWARD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BACKWARD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LEFT     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RIGHT    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SWING    = 3'd5;

    // car drive codes
    localparam logic [CAR_W-1:0] CAR_STOPPED = 3'd0;

    // swing side / swing drive codes
    localparam logic [SWING_W-1:0] SIDE_CENTER = 2'd0;
    localparam logic [SWING_W-1:0] SIDE_LEFT   = 2'd1;
    localparam logic [SWING_W-1:0] SIDE_RIGHT  = 2'd2;

    // action flag
    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_COMMAND = 1'b1;

    typedef struct packed {
        logic [SWING_W-1:0] swing_drive;
        logic [CAR_W-1:0]   car_drive;
        logic               busy_res;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/timed_motor_command_sequencer_top.sv =====
`default_nettype none

// timed motor command sequencer
//
// input stream: s_tuser[0] is the action flag (0 step tick, 1 command),
// s_tdata[2:0] the command code (ignored on a tick). every request gives
// exactly one result on the output stream: m_tdata holds car drive, swing
// drive and busy flag after the request has been applied.
// apb port: move_time 0x00, turn_time 0x04, swing_first_time 0x08,
// swing_return_time 0x0c, step_length 0x10; write only while idle.
// result: registered in the output register, or in the skid register.
// throughput: one request per cycle while s_tready is high; the run state
// updates in one pass of a single compare and subtract/load on the time counter.
// stall: an output register plus one skid register part the two sides, so
// one more request is taken while a result waits; s_tready drops only when
// both hold a result.
// reset (aresetn low, synchronous): drives stopped, not running, registers
// back to their defaults, both result slots empty.

module timed_motor_command_sequencer_top #(
    parameter int TIME_BITS = tmcs_pkg::TIME_BITS_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [tmcs_pkg::S_TDATA_W-1:0]  s_tdata,   // [2:0] command, [7:3] zero
    input  wire logic [0:0]                      s_tuser,   // [0] action
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [tmcs_pkg::M_TDATA_W-1:0]       m_tdata,   // [2:0] car_drive,
                                                            // [4:3] swing_drive,
                                                            // [5] busy_res, [7:6] zero
    // config port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tmcs_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [tmcs_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tmcs_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import tmcs_pkg::*;

    // width for the load path and the expiry compare
    localparam int LOAD_W = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;
    localparam int CMP_W  = (TIME_BITS > STEP_W) ? TIME_BITS : STEP_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_TIME_W-1:0] move_time_reg;
    logic [CFG_TIME_W-1:0] turn_time_reg;
    logic [CFG_TIME_W-1:0] swing_first_reg;
    logic [CFG_TIME_W-1:0] swing_return_reg;
    logic [STEP_W-1:0]     step_length_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_time_reg    <= MOVE_TIME_RST;
            turn_time_reg    <= TURN_TIME_RST;
            swing_first_reg  <= SWING_FIRST_RST;
            swing_return_reg <= SWING_RETURN_RST;
            step_length_reg  <= STEP_LENGTH_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MOVE_TIME:    move_time_reg    <= pwdata[CFG_TIME_W-1:0];
                REG_TURN_TIME:    turn_time_reg    <= pwdata[CFG_TIME_W-1:0];
                REG_SWING_FIRST:  swing_first_reg  <= pwdata[CFG_TIME_W-1:0];
                REG_SWING_RETURN: swing_return_reg <= pwdata[CFG_TIME_W-1:0];
                REG_STEP_LENGTH:  step_length_reg  <= pwdata[STEP_W-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_MOVE_TIME:    prdata = CFG_DATA_W'(move_time_reg);
            REG_TURN_TIME:    prdata = CFG_DATA_W'(turn_time_reg);
            REG_SWING_FIRST:  prdata = CFG_DATA_W'(swing_first_reg);
            REG_SWING_RETURN: prdata = CFG_DATA_W'(swing_return_reg);
            REG_STEP_LENGTH:  prdata = CFG_DATA_W'(step_length_reg);
            default:          prdata = '0;
        endcase
    end

    // loaded times keep the low TIME_BITS bits
    logic [LOAD_W-1:0] move_ext, turn_ext, first_ext, return_ext;
    assign move_ext   = LOAD_W'(move_time_reg);
    assign turn_ext   = LOAD_W'(turn_time_reg);
    assign first_ext  = LOAD_W'(swing_first_reg);
    assign return_ext = LOAD_W'(swing_return_reg);

    // ------------------------------------------------------------------
    // run state
    // ------------------------------------------------------------------
    logic                 running_reg, running_next;
    logic [TIME_BITS-1:0] time_left_reg, time_left_next;
    logic                 swing_mode_reg, swing_mode_next;
    logic [SWING_W-1:0]   swing_side_reg, swing_side_next;
    logic [CAR_W-1:0]     car_motion_reg, car_motion_next;
    logic [SWING_W-1:0]   swing_motion_reg, swing_motion_next;

    logic             in_accept;
    logic [CMD_W-1:0] in_cmd;
    logic [CMP_W-1:0] time_cmp, step_cmp;
    logic             expired;

    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign time_cmp = CMP_W'(time_left_reg);
    assign step_cmp = CMP_W'(step_length_reg);
    assign expired  = (time_cmp <= step_cmp);

    always_comb begin
        running_next      = running_reg;
        time_left_next    = time_left_reg;
        swing_mode_next   = swing_mode_reg;
        swing_side_next   = swing_side_reg;
        car_motion_next   = car_motion_reg;
        swing_motion_next = swing_motion_reg;
        if (s_tuser[0] == ACT_COMMAND) begin
            // every command first stops both drives and clears the run state
            running_next      = 1'b0;
            time_left_next    = '0;
            swing_mode_next   = 1'b0;
            swing_side_next   = SIDE_CENTER;
            car_motion_next   = CAR_STOPPED;
            swing_motion_next = SIDE_CENTER;
            case (in_cmd)
                CMD_FORWARD, CMD_BACKWARD: begin
                    car_motion_next = in_cmd;
                    running_next    = 1'b1;
                    time_left_next  = move_ext[TIME_BITS-1:0];
                end
                CMD_LEFT, CMD_RIGHT: begin
                    car_motion_next = in_cmd;
                    running_next    = 1'b1;
                    time_left_next  = turn_ext[TIME_BITS-1:0];
                end
                CMD_SWING: begin
                    swing_mode_next   = 1'b1;
                    swing_side_next   = SIDE_LEFT;
                    swing_motion_next = SIDE_LEFT;
                    running_next      = 1'b1;
                    time_left_next    = first_ext[TIME_BITS-1:0];
                end
                default: ;  // stop and unused codes leave the block idle
            endcase
        end else if (running_reg) begin
            if (expired) begin
                if (swing_mode_reg) begin
                    // swing leg over: flip side and reload the return time
                    swing_side_next   = (swing_side_reg == SIDE_LEFT) ? SIDE_RIGHT
                                                                      : SIDE_LEFT;
                    swing_motion_next = swing_side_next;
                    time_left_next    = return_ext[TIME_BITS-1:0];
                end else begin
                    running_next      = 1'b0;
                    time_left_next    = '0;
                    car_motion_next   = CAR_STOPPED;
                    swing_motion_next = SIDE_CENTER;
                end
            end else begin
                time_left_next = time_left_reg - TIME_BITS'(step_length_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg      <= 1'b0;
            time_left_reg    <= '0;
            swing_mode_reg   <= 1'b0;
            swing_side_reg   <= SIDE_CENTER;
            car_motion_reg   <= CAR_STOPPED;
            swing_motion_reg <= SIDE_CENTER;
        end else if (in_accept) begin
            running_reg      <= running_next;
            time_left_reg    <= time_left_next;
            swing_mode_reg   <= swing_mode_next;
            swing_side_reg   <= swing_side_next;
            car_motion_reg   <= car_motion_next;
            swing_motion_reg <= swing_motion_next;
        end
    end

    // ------------------------------------------------------------------
    // result register with skid slot
    // ------------------------------------------------------------------
    result_t res_new;
    result_t out_data_reg, skid_data_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    out_take;

    assign res_new.car_drive   = car_motion_next;
    assign res_new.swing_drive = swing_motion_next;
    assign res_new.busy_res    = running_next;

    assign s_tready  = ~skid_valid_reg;
    assign in_accept = s_tvalid & s_tready;
    assign out_take  = out_valid_reg & m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                // skid full means no new request this cycle
                if (out_take) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (!out_valid_reg || out_take) begin
                out_valid_reg <= in_accept;
            end else if (in_accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_take) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (!out_valid_reg || out_take) begin
            if (in_accept) begin
                out_data_reg <= res_new;
            end
        end else if (in_accept) begin
            skid_data_reg <= res_new;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg.busy_res, out_data_reg.swing_drive,
                       out_data_reg.car_drive};

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tmcs_pkg::*;

    // car drive codes that the package leaves out (they follow the command codes)
    localparam logic [CAR_W-1:0] CAR_FORWARD  = 3'd1;
    localparam logic [CAR_W-1:0] CAR_BACKWARD = 3'd2;
    localparam logic [CAR_W-1:0] CAR_LEFT     = 3'd3;
    localparam logic [CAR_W-1:0] CAR_RIGHT    = 3'd4;

    // codes 6 and 7 are not defined and must behave like stop
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    localparam logic [CFG_TIME_W-1:0] TIME_MAX = 24'hFFFFFF;
    localparam logic [STEP_W-1:0]     STEP_MAX = 16'hFFFF;

    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 144;
    localparam int HOLD_OFF_CYCLES  = 80;
    localparam int HOLD_OFF_AFTER   = 300;

    // one result: car drive, swing drive, busy flag
    typedef struct packed {
        logic [CAR_W-1:0]   car;
        logic [SWING_W-1:0] swing;
        logic               busy;
    } drive_state_t;

    typedef enum logic [1:0] {ROW_REQ, ROW_CFG} row_kind_t;

    // one line of the directed script: either a request or a register write
    typedef struct packed {
        row_kind_t           kind;
        logic                act;
        logic [CMD_W-1:0]    cmd;
        logic                pin;     // expected result typed in below
        drive_state_t        want;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [31:0]         value;
    } script_row_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #1 aclk = ~aclk;

    // block inputs, all known from time zero
    logic                  s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [0:0]            s_tuser  = '0;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;

    // block outputs
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // typed-in expectation that travels with the request being offered
    logic         res_pinned = 1'b0;
    drive_state_t pinned_res = '0;

    // no idling on either side once set
    logic quiet = 1'b0;

    // bookkeeping
    drive_state_t pending_drives [$];
    int           mismatch_count = 0;
    int           taken_count    = 0;

    // predicted configuration, starts at the reset defaults
    logic [CFG_TIME_W-1:0] move_len   = MOVE_TIME_RST;
    logic [CFG_TIME_W-1:0] turn_len   = TURN_TIME_RST;
    logic [CFG_TIME_W-1:0] first_leg  = SWING_FIRST_RST;
    logic [CFG_TIME_W-1:0] return_leg = SWING_RETURN_RST;
    logic [STEP_W-1:0]     step_len   = STEP_LENGTH_RST;

    // predicted run state
    logic                  run_on     = 1'b0;
    logic [CFG_TIME_W-1:0] remain     = '0;
    logic                  auto_swing = 1'b0;
    logic [SWING_W-1:0]    side       = SIDE_CENTER;
    logic [CAR_W-1:0]      car_st     = CAR_STOPPED;
    logic [SWING_W-1:0]    swing_st   = SIDE_CENTER;

    timed_motor_command_sequencer_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // apply one request to the predicted state, return the drives it leaves
    function automatic drive_state_t advance_drives(input logic act,
                                                    input logic [CMD_W-1:0] cmd);
        drive_state_t r;
        if (act == ACT_COMMAND) begin
            // every command starts from a full stop
            car_st     = CAR_STOPPED;
            swing_st   = SIDE_CENTER;
            run_on     = 1'b0;
            remain     = '0;
            auto_swing = 1'b0;
            side       = SIDE_CENTER;
            case (cmd)
                CMD_FORWARD, CMD_BACKWARD: begin
                    car_st = cmd;
                    run_on = 1'b1;
                    remain = move_len;
                end
                CMD_LEFT, CMD_RIGHT: begin
                    car_st = cmd;
                    run_on = 1'b1;
                    remain = turn_len;
                end
                CMD_SWING: begin
                    auto_swing = 1'b1;
                    side       = SIDE_LEFT;
                    swing_st   = SIDE_LEFT;
                    run_on     = 1'b1;
                    remain     = first_leg;
                end
                default: ;
            endcase
        end else if (run_on) begin
            if (remain <= {{(CFG_TIME_W-STEP_W){1'b0}}, step_len}) begin
                if (auto_swing) begin
                    // leg used up: flip side and start a return leg
                    side     = (side == SIDE_LEFT) ? SIDE_RIGHT : SIDE_LEFT;
                    swing_st = side;
                    remain   = return_leg;
                end else begin
                    car_st   = CAR_STOPPED;
                    swing_st = SIDE_CENTER;
                    run_on   = 1'b0;
                    remain   = '0;
                end
            end else begin
                remain = remain - {{(CFG_TIME_W-STEP_W){1'b0}}, step_len};
            end
        end
        r.car   = car_st;
        r.swing = swing_st;
        r.busy  = run_on;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t ns: %0s: expected %0d, got %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    function automatic script_row_t pin_row(input logic act, input logic [CMD_W-1:0] cmd,
                                            input logic [CAR_W-1:0] car,
                                            input logic [SWING_W-1:0] swing,
                                            input logic busy);
        script_row_t r;
        r         = '0;
        r.kind    = ROW_REQ;
        r.act     = act;
        r.cmd     = cmd;
        r.pin     = 1'b1;
        r.want    = '{car: car, swing: swing, busy: busy};
        return r;
    endfunction

    function automatic script_row_t free_row(input logic act, input logic [CMD_W-1:0] cmd);
        script_row_t r;
        r      = '0;
        r.kind = ROW_REQ;
        r.act  = act;
        r.cmd  = cmd;
        return r;
    endfunction

    function automatic script_row_t cfg_row(input logic [REG_IDX_W-1:0] idx,
                                            input logic [31:0] value);
        script_row_t r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.value   = value;
        return r;
    endfunction

    // offer one request, with an occasional idle burst before it
    task automatic send_request(input logic act, input logic [CMD_W-1:0] cmd,
                                input logic pin, input drive_state_t pinned);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= act;
        s_tdata    <= {{(S_TDATA_W-CMD_W){1'b0}}, cmd};
        res_pinned <= pin;
        pinned_res <= pinned;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering and let every outstanding result come out
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_drives.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // apb write: setup cycle, access cycle, then back to idle
    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // watch all three ports at the clock edge: register writes feed the
    // predicted configuration, taken requests feed the predictor, results
    // are checked in order
    always @(posedge aclk) begin
        drive_state_t want;
        drive_state_t got;
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_MOVE_TIME:    move_len   = pwdata[CFG_TIME_W-1:0];
                    REG_TURN_TIME:    turn_len   = pwdata[CFG_TIME_W-1:0];
                    REG_SWING_FIRST:  first_leg  = pwdata[CFG_TIME_W-1:0];
                    REG_SWING_RETURN: return_leg = pwdata[CFG_TIME_W-1:0];
                    REG_STEP_LENGTH:  step_len   = pwdata[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want = advance_drives(s_tuser[0], s_tdata[CMD_W-1:0]);
                if (res_pinned)
                    want = pinned_res;
                pending_drives.push_back(want);
                taken_count++;
            end
            if (m_tvalid && m_tready) begin
                got.car   = m_tdata[2:0];
                got.swing = m_tdata[4:3];
                got.busy  = m_tdata[5];
                if (pending_drives.size() == 0) begin
                    report_mismatch("result with no request pending", 0, m_tdata);
                end else begin
                    want = pending_drives.pop_front();
                    if (got.car !== want.car)
                        report_mismatch("car_drive", want.car, got.car);
                    if (got.swing !== want.swing)
                        report_mismatch("swing_drive", want.swing, got.swing);
                    if (got.busy !== want.busy)
                        report_mismatch("busy_res", want.busy, got.busy);
                end
            end
        end
    end

    // result side: random stall bursts, one long hold-off to fill the block,
    // always ready once the run goes quiet
    initial begin
        logic held;
        held = 1'b0;
        forever begin
            if (!quiet && !held && taken_count >= HOLD_OFF_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    // request side and run control
    initial begin
        script_row_t           script [$];
        script_row_t           row;
        logic [CFG_TIME_W-1:0] times [4];
        logic [STEP_W-1:0]     step;
        logic                  act;
        int                    k;

        // directed script, starting from the reset defaults
        // idle tick, with a command code that must be ignored
        script.push_back(pin_row(ACT_TICK, CMD_SWING, CAR_STOPPED, SIDE_CENTER, 1'b0));
        script.push_back(pin_row(ACT_COMMAND, CMD_STOP, CAR_STOPPED, SIDE_CENTER, 1'b0));
        script.push_back(pin_row(ACT_COMMAND, CMD_FORWARD, CAR_FORWARD, SIDE_CENTER, 1'b1));
        script.push_back(pin_row(ACT_TICK, CMD_STOP, CAR_FORWARD, SIDE_CENTER, 1'b1));
        script.push_back(pin_row(ACT_COMMAND, CMD_BACKWARD, CAR_BACKWARD, SIDE_CENTER, 1'b1));
        script.push_back(pin_row(ACT_COMMAND, CMD_LEFT, CAR_LEFT, SIDE_CENTER, 1'b1));
        script.push_back(pin_row(ACT_COMMAND, CMD_RIGHT, CAR_RIGHT, SIDE_CENTER, 1'b1));
        script.push_back(pin_row(ACT_COMMAND, CMD_SWING, CAR_STOPPED, SIDE_LEFT, 1'b1));
        script.push_back(free_row(ACT_TICK, CMD_RSVD7));
        // undefined codes act like stop
        script.push_back(pin_row(ACT_COMMAND, CMD_RSVD6, CAR_STOPPED, SIDE_CENTER, 1'b0));
        script.push_back(pin_row(ACT_COMMAND, CMD_FORWARD, CAR_FORWARD, SIDE_CENTER, 1'b1));
        script.push_back(pin_row(ACT_COMMAND, CMD_RSVD7, CAR_STOPPED, SIDE_CENTER, 1'b0));
        // zero run times: the move still starts, the next tick ends it
        script.push_back(cfg_row(REG_MOVE_TIME, 32'd0));
        script.push_back(cfg_row(REG_TURN_TIME, 32'd0));
        script.push_back(cfg_row(REG_SWING_FIRST, 32'd0));
        script.push_back(cfg_row(REG_SWING_RETURN, 32'd0));
        script.push_back(cfg_row(REG_STEP_LENGTH, 32'd1));
        script.push_back(pin_row(ACT_COMMAND, CMD_FORWARD, CAR_FORWARD, SIDE_CENTER, 1'b1));
        script.push_back(pin_row(ACT_TICK, CMD_STOP, CAR_STOPPED, SIDE_CENTER, 1'b0));
        script.push_back(pin_row(ACT_TICK, CMD_RIGHT, CAR_STOPPED, SIDE_CENTER, 1'b0));
        // swing with zero legs flips side on every tick
        script.push_back(pin_row(ACT_COMMAND, CMD_SWING, CAR_STOPPED, SIDE_LEFT, 1'b1));
        script.push_back(pin_row(ACT_TICK, CMD_STOP, CAR_STOPPED, SIDE_RIGHT, 1'b1));
        script.push_back(pin_row(ACT_TICK, CMD_STOP, CAR_STOPPED, SIDE_LEFT, 1'b1));
        script.push_back(pin_row(ACT_COMMAND, CMD_STOP, CAR_STOPPED, SIDE_CENTER, 1'b0));
        // zero step length: a zero time still ends, a nonzero time never does
        script.push_back(cfg_row(REG_STEP_LENGTH, 32'd0));
        script.push_back(pin_row(ACT_COMMAND, CMD_LEFT, CAR_LEFT, SIDE_CENTER, 1'b1));
        script.push_back(pin_row(ACT_TICK, CMD_STOP, CAR_STOPPED, SIDE_CENTER, 1'b0));
        script.push_back(cfg_row(REG_TURN_TIME, {8'd0, TIME_MAX}));
        script.push_back(pin_row(ACT_COMMAND, CMD_RIGHT, CAR_RIGHT, SIDE_CENTER, 1'b1));
        script.push_back(pin_row(ACT_TICK, CMD_STOP, CAR_RIGHT, SIDE_CENTER, 1'b1));
        // largest step length against the largest time
        script.push_back(cfg_row(REG_STEP_LENGTH, {16'd0, STEP_MAX}));
        script.push_back(free_row(ACT_TICK, CMD_BACKWARD));

        // reset held from time zero, released once and never again
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            row = script[i];
            if (row.kind == ROW_CFG) begin
                settle_idle();
                write_register(row.reg_idx, row.value);
            end else begin
                send_request(row.act, row.cmd, row.pin, row.want);
            end
        end

        // random phases, each with its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle_idle();
            case (ph)
                1: begin
                    foreach (times[j]) times[j] = TIME_MAX;
                    step = STEP_MAX;
                end
                2: begin
                    foreach (times[j]) times[j] = '0;
                    step = 16'd1;
                end
                3: begin
                    foreach (times[j]) times[j] = CFG_TIME_W'($urandom);
                    step = STEP_W'($urandom_range(1, 65535));
                end
                4: begin
                    // zero step: only zero legs ever end
                    foreach (times[j]) times[j] = CFG_TIME_W'($urandom_range(0, 3));
                    step = '0;
                end
                5: begin
                    foreach (times[j]) times[j] = CFG_TIME_W'($urandom_range(0, 2000));
                    step = STEP_W'($urandom_range(1, 500));
                end
                default: begin
                    foreach (times[j]) times[j] = CFG_TIME_W'($urandom_range(0, 300));
                    step = STEP_W'($urandom_range(1, 60));
                end
            endcase
            write_register(REG_MOVE_TIME, {8'd0, times[0]});
            write_register(REG_TURN_TIME, {8'd0, times[1]});
            write_register(REG_SWING_FIRST, {8'd0, times[2]});
            write_register(REG_SWING_RETURN, {8'd0, times[3]});
            write_register(REG_STEP_LENGTH, {16'd0, step});
            if (ph == RANDOM_PHASES - 1)
                quiet = 1'b1;
            // mostly ticks with a command now and then, so moves run to expiry
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                act = ($urandom_range(0, 4) == 0) ? ACT_COMMAND : ACT_TICK;
                send_request(act, CMD_W'($urandom_range(0, 7)), 1'b0, '0);
            end
        end

        // drain, then keep watching for anything stray
        s_tvalid <= 1'b0;
        @(posedge aclk);
        for (k = 0; k < 2000 && pending_drives.size() != 0; k++) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (pending_drives.size() != 0)
            report_mismatch("requests still without result", 0, pending_drives.size());

        if (mismatch_count == 0) begin
            $display("timed_motor_command_sequencer_top verification clean");
        end else begin
            $display("timed_motor_command_sequencer_top verification failed");
        end
        $finish;
    end

    // hang guard
    initial begin
        #500000;
        $display("timed_motor_command_sequencer_top verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tmcs_pkg.sv
hdl/timed_motor_command_sequencer_top.sv
bench/tb.sv
